FILE: src/cbsg_pkg.sv
package cbsg_pkg;

    localparam int STEP_COUNT_DEF = 50;
    localparam int IN_W  = 28;
    localparam int PT_W  = 32;
    localparam int QW    = 40;
    localparam int MAG_W = 34;
    localparam int RLO_W = 18;

    typedef struct packed {
        logic signed [IN_W-1:0] ctrl0_x;
        logic signed [IN_W-1:0] ctrl0_y;
        logic signed [IN_W-1:0] ctrl1_x;
        logic signed [IN_W-1:0] ctrl1_y;
        logic signed [IN_W-1:0] ctrl2_x;
        logic signed [IN_W-1:0] ctrl2_y;
        logic signed [IN_W-1:0] ctrl3_x;
        logic signed [IN_W-1:0] ctrl3_y;
    } t_in;

    typedef struct packed {
        logic signed [PT_W-1:0] seg_start_x;
        logic signed [PT_W-1:0] seg_start_y;
        logic signed [PT_W-1:0] seg_end_x;
        logic signed [PT_W-1:0] seg_end_y;
        logic                   last_segment;
    } t_out;

    typedef struct packed {
        logic [PT_W-1:0] p;
        logic [PT_W-1:0] d1;
        logic [PT_W-1:0] d2;
        logic [PT_W-1:0] d3;
    } t_axis;

endpackage

FILE: src/cbsg_div.sv
module cbsg_div
    import cbsg_pkg::*;
#(
    parameter int DIVISOR = 50
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [QW-1:0]     i_num,
    output logic signed [QW-1:0]     o_quo
);

    localparam int          SH     = MAG_W + $clog2(DIVISOR);
    localparam logic [63:0] RECIP  = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam int          HI_W   = MAG_W - RLO_W + 1;
    localparam int          LO_PW  = MAG_W + RLO_W;
    localparam int          HI_PW  = MAG_W + HI_W;
    localparam int          PROD_W = MAG_W + MAG_W + 1;
    localparam logic [RLO_W-1:0] R_LO = RECIP[RLO_W-1:0];
    localparam logic [HI_W-1:0]  R_HI = RECIP[MAG_W:RLO_W];

    logic [QW-1:0]     w_abs;
    logic              r_neg, r_neg2;
    logic [MAG_W-1:0]  r_mag;
    logic [LO_PW-1:0]  r_plo;
    logic [HI_PW-1:0]  r_phi;
    logic [PROD_W-1:0] w_prod;
    logic [QW-1:0]     w_mq;
    logic [QW-1:0]     r_q;

    assign w_abs  = i_num[QW-1] ? QW'(-i_num) : i_num;
    assign w_prod = (PROD_W'(r_phi) << RLO_W) + PROD_W'(r_plo);
    assign w_mq   = QW'(w_prod >> SH);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg  <= i_num[QW-1];
            r_mag  <= w_abs[MAG_W-1:0];
            r_neg2 <= r_neg;
            r_plo  <= LO_PW'(r_mag) * LO_PW'(R_LO);
            r_phi  <= HI_PW'(r_mag) * HI_PW'(R_HI);
            r_q    <= r_neg2 ? -w_mq : w_mq;
        end
    end

    assign o_quo = $signed(r_q);

endmodule

FILE: src/cbsg_setup.sv
module cbsg_setup
    import cbsg_pkg::*;
#(
    parameter int STEP_COUNT = STEP_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [IN_W-1:0] i_p0,
    input  logic signed [IN_W-1:0] i_p1,
    input  logic signed [IN_W-1:0] i_p2,
    input  logic signed [IN_W-1:0] i_p3,
    output t_axis                  o_axis
);

    localparam int S1 = STEP_COUNT;
    localparam int S2 = STEP_COUNT * STEP_COUNT;
    localparam int S3 = STEP_COUNT * STEP_COUNT * STEP_COUNT;

    logic signed [QW-1:0] r_a, r_b, r_c, r_a6, r_b2;
    logic [PT_W-1:0]      r_p0_s1, r_p0_s2, r_p0_s3, r_p0_s4, r_p0_s5;
    logic signed [QW-1:0] w_qa, w_qb, w_qc, w_qa6, w_qb2;
    logic signed [QW-1:0] e0, e1, e2, e3;
    logic signed [QW-1:0] r_d1, r_d2, r_d3;

    assign e0 = QW'(i_p0);
    assign e1 = QW'(i_p1);
    assign e2 = QW'(i_p2);
    assign e3 = QW'(i_p3);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a  <= (3 * (e1 - e2) + e3) - e0;
            r_b  <= 3 * ((e0 + e2) - 2 * e1);
            r_c  <= 3 * (e1 - e0);
            r_a6 <= 6 * ((3 * (e1 - e2) + e3) - e0);
            r_b2 <= 6 * ((e0 + e2) - 2 * e1);
            r_p0_s1 <= PT_W'(e0);
            r_p0_s2 <= r_p0_s1;
            r_p0_s3 <= r_p0_s2;
            r_p0_s4 <= r_p0_s3;
            r_p0_s5 <= r_p0_s4;
        end
    end

    cbsg_div #(.DIVISOR(S3)) u_da  (.i_clk, .i_en, .i_num(r_a),  .o_quo(w_qa));
    cbsg_div #(.DIVISOR(S2)) u_db  (.i_clk, .i_en, .i_num(r_b),  .o_quo(w_qb));
    cbsg_div #(.DIVISOR(S1)) u_dc  (.i_clk, .i_en, .i_num(r_c),  .o_quo(w_qc));
    cbsg_div #(.DIVISOR(S3)) u_da6 (.i_clk, .i_en, .i_num(r_a6), .o_quo(w_qa6));
    cbsg_div #(.DIVISOR(S2)) u_db2 (.i_clk, .i_en, .i_num(r_b2), .o_quo(w_qb2));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1 <= w_qa + w_qb + w_qc;
            r_d2 <= w_qa6 + w_qb2;
            r_d3 <= w_qa6;
        end
    end

    assign o_axis.p  = r_p0_s5;
    assign o_axis.d1 = r_d1[PT_W-1:0];
    assign o_axis.d2 = r_d2[PT_W-1:0];
    assign o_axis.d3 = r_d3[PT_W-1:0];

endmodule

FILE: src/cbsg_step.sv
module cbsg_step
    import cbsg_pkg::*;
#(
    parameter int STEP_COUNT = STEP_COUNT_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_axis  i_x,
    input  t_axis  i_y,
    output logic   o_valid,
    input  logic   i_ready,
    output t_out   o_data
);

    localparam int CW = $clog2(STEP_COUNT + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    t_axis         r_x, r_y;
    logic          w_adv, w_last, w_load;

    assign w_adv   = r_busy && (!o_valid || i_ready);
    assign w_last  = (r_cnt == CW'(STEP_COUNT - 1));
    assign o_ready = !r_busy || (w_adv && w_last);
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            if (w_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (w_adv) begin
                r_cnt <= r_cnt + CW'(1);
                if (w_last) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_data.seg_start_x  <= r_x.p;
            o_data.seg_start_y  <= r_y.p;
            o_data.seg_end_x    <= r_x.p + r_x.d1;
            o_data.seg_end_y    <= r_y.p + r_y.d1;
            o_data.last_segment <= w_last;
        end
        if (w_load) begin
            r_x <= i_x;
            r_y <= i_y;
        end else if (w_adv) begin
            r_x.p  <= r_x.p + r_x.d1;
            r_y.p  <= r_y.p + r_y.d1;
            r_x.d1 <= r_x.d1 + r_x.d2;
            r_y.d1 <= r_y.d1 + r_y.d2;
            r_x.d2 <= r_x.d2 + r_x.d3;
            r_y.d2 <= r_y.d2 + r_y.d3;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output changed under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt < CW'(STEP_COUNT))
        else $error("step count overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_cnt == CW'(STEP_COUNT - 1) |=> o_data.last_segment)
        else $error("last segment missing");

endmodule

FILE: src/cubic_bezier_segment_gen.sv
// Cubic Bezier segment generator, 16.16 fixed point, forward differencing.
// Input channel: one beat carries the four control points of a curve.
// Output channel: STEP_COUNT beats per curve, each one line segment from the
// previous point to the next, the final beat flagged by last_segment.
// A five-stage pipeline (coefficients, operand magnitude, split reciprocal
// product, signed quotient, sum) forms the differences; a stall in the
// stepper freezes it once its last stage is full; valid bits travel with
// each stage. The stepper emits one segment per cycle while ready is high.
// The single stepper bounds throughput: it loads a new curve only as it
// emits the last segment of the current one; input beats are taken back
// to back while the pipeline has room.
// Reset (synchronous, active low) clears valid bits and the step counter.
// When the receiver holds ready low, the current segment stays on the
// output unchanged and the stepper holds, as does a full pipeline.
module cubic_bezier_segment_gen
    import cbsg_pkg::*;
#(
    parameter int STEP_COUNT = STEP_COUNT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int DEPTH = 5;

    logic [DEPTH-1:0] r_vld;
    logic             w_en, w_step_rdy;
    t_axis            w_x, w_y;

    assign w_en    = !r_vld[DEPTH-1] || w_step_rdy;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    cbsg_setup #(.STEP_COUNT(STEP_COUNT)) u_sx (
        .i_clk, .i_en(w_en),
        .i_p0(i_data.ctrl0_x), .i_p1(i_data.ctrl1_x),
        .i_p2(i_data.ctrl2_x), .i_p3(i_data.ctrl3_x), .o_axis(w_x));
    cbsg_setup #(.STEP_COUNT(STEP_COUNT)) u_sy (
        .i_clk, .i_en(w_en),
        .i_p0(i_data.ctrl0_y), .i_p1(i_data.ctrl1_y),
        .i_p2(i_data.ctrl2_y), .i_p3(i_data.ctrl3_y), .o_axis(w_y));

    cbsg_step #(.STEP_COUNT(STEP_COUNT)) u_step (
        .i_clk, .i_rst_n,
        .i_valid(r_vld[DEPTH-1]), .o_ready(w_step_rdy),
        .i_x(w_x), .i_y(w_y),
        .o_valid, .i_ready, .o_data);

endmodule

FILE: dv/cubic_bezier_segment_gen_tb.sv
module cubic_bezier_segment_gen_tb;
    import cbsg_pkg::*;

    localparam int STEPS = STEP_COUNT_DEF;
    localparam int N_RANDOM = 290;
    localparam int WATCHDOG_LIMIT = 20000;

    class segment_scoreboard;
        t_out segs_q[$];
        int errors;

        function new();
            segs_q = {};
            errors = 0;
        endfunction

        function void axis_diffs(input logic signed [IN_W-1:0] p0, input logic signed [IN_W-1:0] p1,
                                 input logic signed [IN_W-1:0] p2, input logic signed [IN_W-1:0] p3,
                                 output logic [31:0] d1, output logic [31:0] d2,
                                 output logic [31:0] d3);
            longint s1, s2, s3, a, b, c, q0, q1, q2, t3;
            s1 = STEPS;
            s2 = s1 * s1;
            s3 = s2 * s1;
            q0 = p0;
            q1 = p1;
            q2 = p2;
            a = (3 * (q1 - q2) + longint'(p3)) - q0;
            b = 3 * ((q0 + q2) - 2 * q1);
            c = 3 * (q1 - q0);
            t3 = (6 * a) / s3;
            d1 = 32'(a / s3 + b / s2 + c / s1);
            d2 = 32'(t3 + (2 * b) / s2);
            d3 = 32'(t3);
        endfunction

        function void note_curve(input t_in cv);
            logic [31:0] d1x, d2x, d3x, d1y, d2y, d3y, px, py;
            t_out seg;
            axis_diffs(cv.ctrl0_x, cv.ctrl1_x, cv.ctrl2_x, cv.ctrl3_x, d1x, d2x, d3x);
            axis_diffs(cv.ctrl0_y, cv.ctrl1_y, cv.ctrl2_y, cv.ctrl3_y, d1y, d2y, d3y);
            px = 32'(longint'(cv.ctrl0_x));
            py = 32'(longint'(cv.ctrl0_y));
            for (int k = 0; k < STEPS; k++) begin
                seg.seg_start_x = px;
                seg.seg_start_y = py;
                px += d1x;
                py += d1y;
                d1x += d2x;
                d1y += d2y;
                d2x += d3x;
                d2y += d3y;
                seg.seg_end_x = px;
                seg.seg_end_y = py;
                seg.last_segment = (k == STEPS - 1);
                segs_q.push_back(seg);
            end
        endfunction

        function void check_segment(input t_out got);
            t_out exp;
            if (segs_q.size() == 0) begin
                $error("unexpected segment %h", got);
                errors++;
                return;
            end
            exp = segs_q.pop_front();
            if (got.seg_start_x !== exp.seg_start_x) begin
                $error("seg_start_x exp %0d got %0d", exp.seg_start_x, got.seg_start_x);
                errors++;
            end
            if (got.seg_start_y !== exp.seg_start_y) begin
                $error("seg_start_y exp %0d got %0d", exp.seg_start_y, got.seg_start_y);
                errors++;
            end
            if (got.seg_end_x !== exp.seg_end_x) begin
                $error("seg_end_x exp %0d got %0d", exp.seg_end_x, got.seg_end_x);
                errors++;
            end
            if (got.seg_end_y !== exp.seg_end_y) begin
                $error("seg_end_y exp %0d got %0d", exp.seg_end_y, got.seg_end_y);
                errors++;
            end
            if (got.last_segment !== exp.last_segment) begin
                $error("last_segment exp %0b got %0b", exp.last_segment, got.last_segment);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in  i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;

    segment_scoreboard sb = new();
    bit   calm = 1'b0;
    bit   sink_on = 1'b0;
    int   idle_cycles = 0;

    cubic_bezier_segment_gen dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            sb.note_curve(i_data);
        end
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_segment(o_data);
        end
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("cubic_bezier_segment_gen: mismatch");
            $finish;
        end
        if (sink_on) begin
            i_ready <= calm || ($urandom_range(99) >= 36);
        end
    end

    function automatic logic [IN_W-1:0] pick_coord();
        case ($urandom_range(5))
            0: return {1'b0, {(IN_W-1){1'b1}}};
            1: return {1'b1, {(IN_W-1){1'b0}}};
            2: return IN_W'($urandom_range(2000) - 1000);
            default: return IN_W'($urandom);
        endcase
    endfunction

    task automatic send_curve(input t_in cv);
        while (!calm && $urandom_range(99) < 36) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= cv;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_random();
        t_in cv;
        cv.ctrl0_x = pick_coord();
        cv.ctrl0_y = pick_coord();
        cv.ctrl1_x = pick_coord();
        cv.ctrl1_y = pick_coord();
        cv.ctrl2_x = pick_coord();
        cv.ctrl2_y = pick_coord();
        cv.ctrl3_x = pick_coord();
        cv.ctrl3_y = pick_coord();
        send_curve(cv);
    endtask

    initial begin
        t_in cv;
        int wait_cnt;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sink_on <= 1'b1;
        @(posedge i_clk);

        cv = '0;
        send_curve(cv);
        cv = {8{1'b0, {(IN_W-1){1'b1}}}};
        send_curve(cv);
        cv = {8{1'b1, {(IN_W-1){1'b0}}}};
        send_curve(cv);
        cv = {8{ {IN_W{1'b1}} }};
        send_curve(cv);
        cv = '0;
        cv.ctrl1_x = {1'b0, {(IN_W-1){1'b1}}};
        cv.ctrl1_y = {1'b1, {(IN_W-1){1'b0}}};
        cv.ctrl2_x = {1'b1, {(IN_W-1){1'b0}}};
        cv.ctrl2_y = {1'b0, {(IN_W-1){1'b1}}};
        send_curve(cv);
        cv = '0;
        cv.ctrl0_x = {1'b0, {(IN_W-1){1'b1}}};
        cv.ctrl3_x = {1'b1, {(IN_W-1){1'b0}}};
        cv.ctrl0_y = {1'b1, {(IN_W-1){1'b0}}};
        cv.ctrl3_y = {1'b0, {(IN_W-1){1'b1}}};
        send_curve(cv);
        cv = '0;
        cv.ctrl3_x = -IN_W'(7);
        cv.ctrl1_y = IN_W'(3);
        send_curve(cv);
        for (int i = 0; i < 8; i++) begin
            send_random();
        end
        i_valid <= 1'b0;

        wait_cnt = 0;
        while (sb.segs_q.size() != 0 && wait_cnt < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            wait_cnt++;
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            calm = (i >= 100 && i < 150);
            send_random();
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        wait_cnt = 0;
        while (sb.segs_q.size() != 0 && wait_cnt < 40 * WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.segs_q.size() == 0) begin
            $display("cubic_bezier_segment_gen: match");
        end else begin
            $display("cubic_bezier_segment_gen: mismatch");
        end
        $finish;
    end
endmodule

FILE: files.f
src/cbsg_pkg.sv
src/cbsg_div.sv
src/cbsg_setup.sv
src/cbsg_step.sv
src/cubic_bezier_segment_gen.sv
dv/cubic_bezier_segment_gen_tb.sv
